>>> src/mcg_pkg.sv
package mcg_pkg;

  localparam int CLICK_ROM_DEPTH = 1323;
  localparam int SAMPLE_RATE     = 44100;
  localparam int ADDR_W          = $clog2(CLICK_ROM_DEPTH);

  localparam int POS_W  = 24;
  localparam int FRAC_W = 12;
  localparam int IDX_W  = POS_W - FRAC_W;
  localparam int RATE_W = 16;
  localparam int SAMP_W = 16;
  localparam int SPB_W  = 24;
  localparam int BPB_W  = 8;
  localparam int CFG_W  = 24;
  localparam int REG_W  = 3;

  localparam logic [REG_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [REG_W-1:0] REG_SAMPLES_BEAT = 3'd1;
  localparam logic [REG_W-1:0] REG_BEATS_BAR   = 3'd2;
  localparam logic [REG_W-1:0] REG_ACCENT_RATE = 3'd3;
  localparam logic [REG_W-1:0] REG_NORMAL_RATE = 3'd4;

  localparam logic [RATE_W-1:0] MIN_RATE     = 16'd410;
  localparam logic [RATE_W-1:0] RESET_ACCENT = 16'd5120;
  localparam logic [RATE_W-1:0] RESET_NORMAL = 16'd4096;
  localparam logic [SPB_W-1:0]  RESET_SPB    = 24'd22050;
  localparam logic [BPB_W-1:0]  RESET_BPB    = 8'd4;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] AMP_Q30     = 64'd375809638;

  typedef logic signed [SAMP_W-1:0] click_rom_t [CLICK_ROM_DEPTH];

  // Per-tick control handed from the state update to the read/interpolate stages.
  typedef struct packed {
    logic              beat;
    logic              accent;
    logic              active;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [FRAC_W-1:0] frac;
  } tick_t;

  // Q30 quarter-wave sine, truncating Horner form.
  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    a  = (u * HALF_PI_Q30) >> 30;
    a2 = (a * a) >> 30;
    t  = Q30_ONE - a2 / 64'd72;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((a2 * t) >> 30) / 64'd6;
    return (a * t) >> 30;
  endfunction

  // Decaying 1600 Hz click, evaluated at elaboration.
  function automatic click_rom_t build_click_rom();
    click_rom_t  rom;
    logic [63:0] inc;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [63:0] decay;
    logic [63:0] env;
    logic [63:0] prod;
    logic [31:0] ph;
    logic [63:0] u;
    logic [63:0] m;
    logic [31:0] v;
    inc   = (64'd1600 << 32) / 64'(SAMPLE_RATE);
    x     = (64'd60 << 30) / 64'(SAMPLE_RATE);
    x2    = (x * x) >> 30;
    x3    = (x2 * x) >> 30;
    decay = Q30_ONE - x + x2 / 64'd2 - x3 / 64'd6;
    env   = Q30_ONE;
    for (int i = 0; i < CLICK_ROM_DEPTH; i++) begin
      prod = 64'(i) * inc;
      ph   = prod[31:0];
      u    = {34'd0, ph[29:0]};
      if (ph[30]) begin
        u = Q30_ONE - u;
      end
      m = (quarter_sine(u) * env) >> 30;
      m = (m * AMP_Q30) >> 30;
      v = 32'((m + 64'd16384) >> 15);
      if (ph[31]) begin
        v = -v;
      end
      rom[i] = v[SAMP_W-1:0];
      env = (env * decay + (64'd1 << 29)) >> 30;
    end
    return rom;
  endfunction

endpackage

>>> src/mcg_rom.sv
module mcg_rom (
  input  logic                              clk,
  input  logic                              en,
  input  logic [mcg_pkg::ADDR_W-1:0]        addr0,
  input  logic [mcg_pkg::ADDR_W-1:0]        addr1,
  output logic signed [mcg_pkg::SAMP_W-1:0] data0,
  output logic signed [mcg_pkg::SAMP_W-1:0] data1
);
  import mcg_pkg::*;

  localparam click_rom_t ROM = build_click_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data0 <= ROM[addr0];
      data1 <= ROM[addr1];
    end
  end

endmodule

>>> src/mcg_ctrl.sv
module mcg_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [mcg_pkg::REG_W-1:0]   wr_index,
  input  logic [mcg_pkg::CFG_W-1:0]   wr_data,
  input  logic                        step,
  input  logic                        restart,
  output mcg_pkg::tick_t              tick
);
  import mcg_pkg::*;

  logic              enable;
  logic [SPB_W-1:0]  samples_per_beat;
  logic [BPB_W-1:0]  beats_per_bar;
  logic [RATE_W-1:0] accent_rate;
  logic [RATE_W-1:0] normal_rate;

  logic [SPB_W-1:0]  beat_phase;
  logic [BPB_W-1:0]  bar_position;
  logic              click_on;
  logic [POS_W-1:0]  read_position;
  logic [RATE_W-1:0] current_rate;

  logic [SPB_W-1:0]  beat_phase_next;
  logic [BPB_W-1:0]  bar_position_next;
  logic              click_on_next;
  logic [POS_W-1:0]  read_position_next;
  logic [RATE_W-1:0] current_rate_next;

  logic [SPB_W-1:0]  bp;
  logic [BPB_W-1:0]  bar;
  logic              con;
  logic [POS_W-1:0]  rp;
  logic [RATE_W-1:0] rate;
  logic [SPB_W:0]    phase_inc;
  logic [SPB_W-1:0]  spb_eff;
  logic [BPB_W:0]    bar_inc;
  logic [BPB_W-1:0]  bpb_eff;
  logic [IDX_W-1:0]  idx;
  logic [POS_W:0]    pos_sum;
  logic [RATE_W-1:0] wr_rate;

  assign wr_rate = (wr_data[RATE_W-1:0] < MIN_RATE) ? MIN_RATE : wr_data[RATE_W-1:0];

  always_comb begin
    bp      = beat_phase;
    bar     = bar_position;
    con     = click_on;
    rp      = read_position;
    rate    = current_rate;
    spb_eff = (samples_per_beat == '0) ? SPB_W'(1) : samples_per_beat;
    bpb_eff = (beats_per_bar == '0) ? BPB_W'(1) : beats_per_bar;
    tick    = '0;

    if (restart) begin
      bp   = '0;
      bar  = '0;
      con  = 1'b0;
      rp   = '0;
      rate = normal_rate;
    end

    if (bp == '0) begin
      tick.beat   = 1'b1;
      tick.accent = (bar == '0);
      con         = 1'b1;
      rp          = '0;
      rate        = (bar == '0) ? accent_rate : normal_rate;
      bar_inc     = {1'b0, bar} + 1'b1;
      bar         = (bar_inc >= {1'b0, bpb_eff}) ? '0 : bar_inc[BPB_W-1:0];
    end else begin
      bar_inc = '0;
    end

    idx     = rp[POS_W-1:FRAC_W];
    pos_sum = {1'b0, rp} + {{(POS_W+1-RATE_W){1'b0}}, rate};
    tick.frac  = rp[FRAC_W-1:0];
    tick.addr0 = idx[ADDR_W-1:0];
    tick.addr1 = (idx == IDX_W'(CLICK_ROM_DEPTH - 1)) ? idx[ADDR_W-1:0]
                                                      : ADDR_W'(idx + 1'b1);
    if (con) begin
      if (idx >= IDX_W'(CLICK_ROM_DEPTH)) begin
        con = 1'b0;
        rp  = '0;
      end else begin
        tick.active = 1'b1;
        rp = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
      end
    end

    phase_inc = {1'b0, bp} + 1'b1;
    bp = (phase_inc >= {1'b0, spb_eff}) ? '0 : phase_inc[SPB_W-1:0];

    // Disabled ticks give silence and leave the counters alone.
    if (!enable) begin
      tick = '0;
    end

    beat_phase_next    = bp;
    bar_position_next  = bar;
    click_on_next      = con;
    read_position_next = rp;
    current_rate_next  = rate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable           <= 1'b0;
      samples_per_beat <= RESET_SPB;
      beats_per_bar    <= RESET_BPB;
      accent_rate      <= RESET_ACCENT;
      normal_rate      <= RESET_NORMAL;
      beat_phase       <= '0;
      bar_position     <= '0;
      click_on         <= 1'b0;
      read_position    <= '0;
      current_rate     <= RESET_NORMAL;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENABLE: begin
          if (wr_data[0] && !enable) begin
            beat_phase    <= '0;
            bar_position  <= '0;
            click_on      <= 1'b0;
            read_position <= '0;
            current_rate  <= normal_rate;
          end
          enable <= wr_data[0];
        end
        REG_SAMPLES_BEAT: samples_per_beat <= wr_data[SPB_W-1:0];
        REG_BEATS_BAR: begin
          beats_per_bar <= wr_data[BPB_W-1:0];
          bar_position  <= '0;
        end
        REG_ACCENT_RATE: accent_rate <= wr_rate;
        REG_NORMAL_RATE: normal_rate <= wr_rate;
        default: ;
      endcase
    end else if (step && enable) begin
      beat_phase    <= beat_phase_next;
      bar_position  <= bar_position_next;
      click_on      <= click_on_next;
      read_position <= read_position_next;
      current_rate  <= current_rate_next;
    end
  end

endmodule

>>> src/mcg_interp.sv
module mcg_interp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_ok,
  output logic                              ready,
  input  logic                              beat,
  input  logic                              accent_in,
  input  logic                              active,
  input  logic [mcg_pkg::FRAC_W-1:0]        frac,
  input  logic signed [mcg_pkg::SAMP_W-1:0] t0,
  input  logic signed [mcg_pkg::SAMP_W-1:0] t1,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [mcg_pkg::SAMP_W-1:0] sample,
  output logic                              beat_start,
  output logic                              accent
);
  import mcg_pkg::*;

  localparam int PROD_W = SAMP_W + FRAC_W + 2;
  localparam int SUM_W  = PROD_W + 1;

  logic                     prod_valid;
  logic                     prod_beat;
  logic                     prod_accent;
  logic signed [PROD_W-1:0] p0;
  logic signed [PROD_W-1:0] p1;
  logic                     out_ready;
  logic [FRAC_W:0]          w0;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-FRAC_W-1:0] rounded;
  logic signed [SAMP_W-1:0] sat;

  assign out_ready = !result_valid || !result_stall;
  assign ready     = !prod_valid || out_ready;
  assign w0        = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, frac};

  always_comb begin
    sum     = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(1 << (FRAC_W - 1));
    rounded = sum[SUM_W-1:FRAC_W];
    if (rounded > (SUM_W-FRAC_W)'(32767)) begin
      sat = 16'sh7fff;
    end else if (rounded < -(SUM_W-FRAC_W)'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = rounded[SAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready) begin
        prod_valid <= in_ok;
      end
      if (out_ready) begin
        result_valid <= prod_valid;
      end
    end
    if (ready) begin
      prod_beat   <= beat;
      prod_accent <= accent_in;
      // Inactive click: zero products give a zero sample.
      p0 <= active ? t0 * $signed({1'b0, w0}) : $signed(PROD_W'(0));
      p1 <= active ? t1 * $signed({2'b00, frac}) : $signed(PROD_W'(0));
    end
    if (out_ready) begin
      sample     <= sat;
      beat_start <= prod_beat;
      accent     <= prod_accent;
    end
  end

endmodule

>>> src/metronome_click_generator.sv
// Metronome click generator.
// Tick channel (tick_valid / tick_stall / restart): one tick per audio sample.
// Result channel (result_valid / result_stall / sample, beat_start, accent):
// one result per tick, in order, signed Q1.15 sample plus beat flags.
// Config port (wr_en / wr_index / wr_data): 0 enable, 1 samples_per_beat,
// 2 beats_per_bar, 3 accent_rate, 4 normal_rate; write only while idle.
// Throughput: one tick per cycle unless tick_stall is high. A result passes
// through three register stages: counter update and click ROM read, the two
// interpolation products, then sum, round and saturate into the output reg.
// The click ROM is a constant two-port table; it needs no init after reset.
// Reset loads register defaults with the block disabled; disabled ticks
// return silence and leave the counters untouched.
// When result_stall is high, each stage holds once the stage after it is
// full; tick_stall rises only when all three stages hold ticks.
module metronome_click_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [mcg_pkg::REG_W-1:0]         wr_index,
  input  logic [mcg_pkg::CFG_W-1:0]         wr_data,
  input  logic                              tick_valid,
  output logic                              tick_stall,
  input  logic                              restart,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [mcg_pkg::SAMP_W-1:0] sample,
  output logic                              beat_start,
  output logic                              accent
);
  import mcg_pkg::*;

  tick_t                    tick;
  tick_t                    rd_tick;
  logic                     rd_valid;
  logic                     rd_load;
  logic                     interp_ready;
  logic                     step;
  logic signed [SAMP_W-1:0] t0;
  logic signed [SAMP_W-1:0] t1;

  assign rd_load    = !rd_valid || interp_ready;
  assign tick_stall = !rd_load;
  assign step       = tick_valid && rd_load;

  mcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .step     (step),
    .restart  (restart),
    .tick     (tick)
  );

  mcg_rom u_rom (
    .clk   (clk),
    .en    (rd_load),
    .addr0 (tick.addr0),
    .addr1 (tick.addr1),
    .data0 (t0),
    .data1 (t1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_load) begin
      rd_valid <= tick_valid;
    end
    if (rd_load) begin
      rd_tick <= tick;
    end
  end

  mcg_interp u_interp (
    .clk          (clk),
    .rst          (rst),
    .in_ok        (rd_valid),
    .ready        (interp_ready),
    .beat         (rd_tick.beat),
    .accent_in    (rd_tick.accent),
    .active       (rd_tick.active),
    .frac         (rd_tick.frac),
    .t0           (t0),
    .t1           (t1),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample       (sample),
    .beat_start   (beat_start),
    .accent       (accent)
  );

  a_accent_on_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && accent |-> beat_start)
    else $error("accent without beat_start");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> rd_valid)
    else $error("tick stalled with empty read stage");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    tick_valid && !tick_stall |=> rd_valid)
    else $error("accepted tick lost");

  a_silent_when_idle: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !rd_tick.beat |-> !rd_tick.accent)
    else $error("accent flagged off a beat");

endmodule
